### hw/rtl/bslp_pkg.sv
// ----------------------------------------------------------------------------
// bslp_pkg
// shared types and constants of the two-button press classifier
// ----------------------------------------------------------------------------
package bslp_pkg;

    localparam int CNT_W = 16;
    localparam int CFG_W = 16;
    localparam int IDX_W = 1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // register indexes
    localparam logic [IDX_W-1:0] REG_DEBOUNCE = 1'b0;
    localparam logic [IDX_W-1:0] REG_LONG     = 1'b1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd2;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd100;

    // class codes of button one
    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_SHORT = 2'd1;
    localparam logic [1:0] CLS_LONG  = 2'd2;

    // release seen on a held button, with the finished hold length
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] ticks;
    } t_hold_evt;

endpackage

### hw/rtl/bslp_hold.sv
// ----------------------------------------------------------------------------
// bslp_hold
// hold tracker of one button: held flag and saturating hold counter
// ----------------------------------------------------------------------------
module bslp_hold (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_edge,
    input  logic                i_released,
    output bslp_pkg::t_hold_evt o_evt
);

    logic                       r_held;
    logic                       n_held;
    logic [bslp_pkg::CNT_W-1:0] r_ticks;
    logic [bslp_pkg::CNT_W-1:0] n_ticks;
    logic [bslp_pkg::CNT_W-1:0] ticks_inc;
    logic                       held_after;

    // saturating advance
    assign ticks_inc = (r_ticks == bslp_pkg::CNT_MAX) ? r_ticks
                                                      : r_ticks + 1'b1;

    assign o_evt.done  = r_held & i_released;
    assign o_evt.ticks = ticks_inc;

    assign held_after = r_held & ~i_released;

    always_comb begin
        n_held  = r_held;
        n_ticks = r_ticks;
        if (i_step) begin
            n_held = held_after;
            if (r_held) begin
                n_ticks = ticks_inc;
            end
            // a new hold starts only on a button that is not held after this tick's release
            if (i_edge && !held_after) begin
                n_held  = 1'b1;
                n_ticks = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_ticks <= '0;
        end else begin
            r_held  <= n_held;
            r_ticks <= n_ticks;
        end
    end

endmodule

### hw/rtl/bslp_class.sv
// ----------------------------------------------------------------------------
// bslp_class
// clear and classify step: next latched results of both buttons
// ----------------------------------------------------------------------------
module bslp_class (
    input  logic                       i_clear_one,
    input  logic                       i_clear_two,
    input  bslp_pkg::t_hold_evt        i_evt_one,
    input  bslp_pkg::t_hold_evt        i_evt_two,
    input  logic [bslp_pkg::CFG_W-1:0] i_debounce,
    input  logic [bslp_pkg::CFG_W-1:0] i_long,
    input  logic [1:0]                 i_latched_one,
    input  logic                       i_latched_two,
    output logic [1:0]                 o_latched_one,
    output logic                       o_latched_two
);

    always_comb begin
        o_latched_one = i_clear_one ? bslp_pkg::CLS_NONE : i_latched_one;
        if (i_evt_one.done) begin
            if (i_evt_one.ticks >= i_long) begin
                o_latched_one = bslp_pkg::CLS_LONG;
            end else if (i_evt_one.ticks >= i_debounce) begin
                o_latched_one = bslp_pkg::CLS_SHORT;
            end
        end
    end

    always_comb begin
        o_latched_two = i_clear_two ? 1'b0 : i_latched_two;
        if (i_evt_two.done && (i_evt_two.ticks >= i_debounce)) begin
            o_latched_two = 1'b1;
        end
    end

endmodule

### hw/rtl/button_short_long_press_classifier.sv
// ----------------------------------------------------------------------------
// button_short_long_press_classifier
// two-button debounce and short/long press classifier, one timer tick a beat
// ----------------------------------------------------------------------------
// Each input beat is one timer tick carrying a press edge, the pin level
// (1 = released) and a clear request for each of two buttons. A tick first
// clears the requested latches, then classifies every held button whose pin
// reads released, then starts a hold on an edge of a button that is not held.
// Button one latches short for a hold from debounce_ticks up to below
// long_press_ticks and long at or above long_press_ticks; button two latches
// short for any hold of at least debounce_ticks; shorter holds change nothing.
// Hold counters saturate at 65535. The result beat carries both latched
// values after the tick. One beat per clock while the output is not stalled,
// each result in the cycle after its tick; the state update and the output
// register are one and the same register stage, and a new tick is taken
// whenever the output register is empty or being drained in the same cycle.
// Configuration writes are to be made only while no tick is in flight.
// ----------------------------------------------------------------------------
module button_short_long_press_classifier (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [bslp_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [bslp_pkg::CFG_W-1:0] i_cfg_data,
    // tick beats
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_edge_one,
    input  logic                       i_edge_two,
    input  logic                       i_released_one,
    input  logic                       i_released_two,
    input  logic                       i_clear_one,
    input  logic                       i_clear_two,
    // result beats
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_press_one,
    output logic                       o_press_two
);

    // configuration registers
    logic [bslp_pkg::CFG_W-1:0] r_debounce;
    logic [bslp_pkg::CFG_W-1:0] r_long;

    // latched results double as the output register
    logic [1:0] r_latched_one;
    logic [1:0] n_latched_one;
    logic       r_latched_two;
    logic       n_latched_two;
    logic       r_out_valid;

    logic                step;
    bslp_pkg::t_hold_evt evt_one;
    bslp_pkg::t_hold_evt evt_two;

    // take a tick when the result slot is free or drains this cycle
    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign step       = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= bslp_pkg::DEBOUNCE_RST;
            r_long     <= bslp_pkg::LONG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bslp_pkg::REG_DEBOUNCE: begin
                    r_debounce <= i_cfg_data;
                end
                bslp_pkg::REG_LONG: begin
                    r_long <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // per-button hold trackers
    bslp_hold u_hold_one (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_edge     (i_edge_one),
        .i_released (i_released_one),
        .o_evt      (evt_one)
    );

    bslp_hold u_hold_two (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_edge     (i_edge_two),
        .i_released (i_released_two),
        .o_evt      (evt_two)
    );

    // clear then classify
    bslp_class u_class (
        .i_clear_one   (i_clear_one),
        .i_clear_two   (i_clear_two),
        .i_evt_one     (evt_one),
        .i_evt_two     (evt_two),
        .i_debounce    (r_debounce),
        .i_long        (r_long),
        .i_latched_one (r_latched_one),
        .i_latched_two (r_latched_two),
        .o_latched_one (n_latched_one),
        .o_latched_two (n_latched_two)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched_one <= bslp_pkg::CLS_NONE;
            r_latched_two <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (step) begin
                r_latched_one <= n_latched_one;
                r_latched_two <= n_latched_two;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_press_one = r_latched_one;
    assign o_press_two = r_latched_two;

endmodule

### hw/rtl/bslp_checker.sv
// ----------------------------------------------------------------------------
// bslp_checker
// port-level checks of the press classifier, bound to the top level
// ----------------------------------------------------------------------------
module bslp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_press_one,
    input logic       o_press_two
);

    // an empty result slot always takes a tick
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready with empty result slot");

    // every accepted tick yields a result beat next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted tick gave no result");

    // a stalled result holds its value
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_press_one) && $stable(o_press_two)))
        else $error("stalled result changed");

    // button one never shows the unused code
    a_press_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_press_one != 2'd3))
        else $error("button one press code out of range");

endmodule

bind button_short_long_press_classifier bslp_checker u_bslp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_press_one (o_press_one),
    .o_press_two (o_press_two)
);
